FILE: rtl/core/rbp_pkg.sv
`timescale 1ns / 1ps

package rbp_pkg;

    // field widths of the word on each channel
    localparam int MODE_W     = 2;
    localparam int ELAPSED_W  = 26;
    localparam int COUNT_W    = 16;
    localparam int GEN_W      = 32;
    localparam int SEQ_W      = 16;
    localparam int LEN_W      = 16;
    localparam int RATE_W     = 32;
    localparam int VERDICT_W  = 2;
    localparam int INDEX_W    = 16;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MULT_W      = 12;
    localparam int CAP_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_MULT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION_CAP = 1'd1;

    localparam logic [MULT_W-1:0] RATE_MULT_RESET    = 12'd256;
    localparam logic [CAP_W-1:0]  DURATION_CAP_RESET = 16'd10000;

    // item modes
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TERM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POLL  = 2'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_SEND = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_WAIT = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DONE = 2'd2;

    // rate arithmetic
    // nominal x 4.8 multiplier, dropping the fraction, fits 36 bits
    localparam int PROD_NM_W  = RATE_W + MULT_W;
    localparam int MULT_FRAC  = 8;
    localparam int TARGET_W   = PROD_NM_W - MULT_FRAC;
    localparam int HALF_W     = TARGET_W / 2;
    localparam int PART_W     = HALF_W + ELAPSED_W;
    localparam int BUDGET_W   = TARGET_W + ELAPSED_W;
    // 8 bits per byte times 1e6 microseconds per second
    localparam int SCALE_W    = 23;
    localparam logic [SCALE_W-1:0] BIT_US_SCALE = 23'd8000000;
    localparam int LEN_SCALED_W = LEN_W + SCALE_W;
    // at most 65535 sends of 65535 bytes between starts: below 2^32 bytes
    localparam int SENT_W     = 32;
    localparam int SCALED_W   = SENT_W + SCALE_W;
    localparam int MS_W       = 10;
    localparam logic [MS_W-1:0] US_PER_MS = 10'd1000;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [COUNT_W-1:0]   cache_count;
        logic [GEN_W-1:0]     channel_generation;
        logic                 entry_valid;
        logic [SEQ_W-1:0]     entry_seq;
        logic [LEN_W-1:0]     entry_len;
        logic [RATE_W-1:0]    base_rate_bps;
        logic [RATE_W-1:0]    client_cap_bps;
        logic                 stop_requested;
        logic [SEQ_W-1:0]     halt_seq;
    } item_word_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [INDEX_W-1:0]   entry_index;
        logic [SEQ_W-1:0]     send_seq;
        logic                 finished;
    } result_word_t;

endpackage

FILE: rtl/core/retransmit_burst_pacer_unit.sv
`timescale 1ns / 1ps

// Retransmission burst pacer. Takes one word per cycle (start, terminate or poll)
// unless result_ready stalls the pipeline, and returns exactly one result word for
// each through three registers: input register, a stage holding the split
// rate x elapsed products, and the result register where the burst state (cursor,
// sent-byte budget, stop sequence, generation) is updated. The rate target is set as
// a start leaves the input register, so a poll right behind it already sees it.
// Configuration writes are taken every cycle and should be made only while no word
// is in flight.
module retransmit_burst_pacer_unit #(
    parameter int INDEX_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rbp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rbp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  rbp_pkg::item_word_t                  item,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output rbp_pkg::result_word_t                result
);

    import rbp_pkg::*;

    localparam logic [31:0] IDX_MAX = 32'((64'd1 << INDEX_BITS) - 64'd1);

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [GEN_W-1:0]        generation;
        logic                    entry_valid;
        logic [SEQ_W-1:0]        entry_seq;
        logic                    stop_requested;
        logic [SEQ_W-1:0]        halt_seq;
        logic [INDEX_BITS-1:0]   count;
        logic                    cap_hit;
        logic [PART_W-1:0]       budget_lo;
        logic [PART_W-1:0]       budget_hi;
        logic [LEN_SCALED_W-1:0] len_scaled;
    } stage2_t;

    // configuration registers
    logic [MULT_W-1:0] rate_mult_reg;
    logic [CAP_W-1:0]  dur_cap_reg;

    // pipeline registers
    logic          s1_valid_reg;
    item_word_t    s1_reg;
    logic          s2_valid_reg;
    stage2_t       s2_reg;
    stage2_t       s2_next;
    logic          result_valid_reg;
    result_word_t  result_reg;
    result_word_t  result_next;

    // burst state
    logic [TARGET_W-1:0]   target_reg;
    logic [TARGET_W-1:0]   target_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  stop_armed_reg;
    logic                  stop_armed_next;
    logic [SEQ_W-1:0]      halt_seq_reg;
    logic [SEQ_W-1:0]      halt_seq_next;
    logic [GEN_W-1:0]      start_gen_reg;
    logic [GEN_W-1:0]      start_gen_next;
    logic [SCALED_W-1:0]   sent_scaled_reg;
    logic [SCALED_W-1:0]   sent_scaled_next;
    logic [INDEX_BITS-1:0] cursor_reg;
    logic [INDEX_BITS-1:0] cursor_next;

    // stage enables
    logic en_out;
    logic en2;
    logic en1;

    // stage 1 datapath
    logic [PROD_NM_W-1:0]  nominal_scaled;
    logic [TARGET_W-1:0]   target_raw;
    logic [ELAPSED_W-1:0]  cap_us;
    logic [31:0]           count_ext;

    // stage 2 datapath
    logic [BUDGET_W-1:0]   budget;
    logic                  budget_spent;
    logic [SEQ_W-1:0]      seq_gap;
    logic                  send;

    assign en_out     = !result_valid_reg || result_ready;
    assign en2        = !s2_valid_reg || en_out;
    assign en1        = !s1_valid_reg || en2;
    assign item_ready = en1;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mult_reg <= RATE_MULT_RESET;
            dur_cap_reg   <= DURATION_CAP_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_RATE_MULT)
            begin
                rate_mult_reg <= cfg_data[MULT_W-1:0];
            end
            if (cfg_index == CFG_DURATION_CAP)
            begin
                dur_cap_reg <= cfg_data[CAP_W-1:0];
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && item_valid)
        begin
            s1_reg <= item;
        end
    end

    // start target: nominal x multiplier, then the client limit
    always_comb
    begin
        nominal_scaled = PROD_NM_W'(s1_reg.base_rate_bps) * PROD_NM_W'(rate_mult_reg);
        target_raw     = nominal_scaled[PROD_NM_W-1:MULT_FRAC];
        if (s1_reg.client_cap_bps != '0 && TARGET_W'(s1_reg.client_cap_bps) < target_raw)
        begin
            target_next = TARGET_W'(s1_reg.client_cap_bps);
        end
        else
        begin
            target_next = target_raw;
        end
    end

    // a start updates the target as it leaves stage 1, so later polls see it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (en2 && s1_valid_reg && s1_reg.mode == MODE_START)
        begin
            target_reg <= target_next;
        end
    end

    // stage 1 products and compares
    always_comb
    begin
        cap_us    = ELAPSED_W'(dur_cap_reg) * ELAPSED_W'(US_PER_MS);
        count_ext = 32'(s1_reg.cache_count);

        s2_next.mode           = s1_reg.mode;
        s2_next.generation     = s1_reg.channel_generation;
        s2_next.entry_valid    = s1_reg.entry_valid;
        s2_next.entry_seq      = s1_reg.entry_seq;
        s2_next.stop_requested = s1_reg.stop_requested;
        s2_next.halt_seq       = s1_reg.halt_seq;
        s2_next.count          = (count_ext > IDX_MAX) ? IDX_MAX[INDEX_BITS-1:0]
                                                       : count_ext[INDEX_BITS-1:0];
        s2_next.cap_hit        = s1_reg.elapsed_us >= cap_us;
        s2_next.budget_lo      = PART_W'(target_reg[HALF_W-1:0]) * PART_W'(s1_reg.elapsed_us);
        s2_next.budget_hi      = PART_W'(target_reg[TARGET_W-1:HALF_W])
                                 * PART_W'(s1_reg.elapsed_us);
        s2_next.len_scaled     = LEN_SCALED_W'(s1_reg.entry_len) * LEN_SCALED_W'(BIT_US_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // budget compare: sent bytes x 8e6 against target x elapsed
    always_comb
    begin
        budget       = (BUDGET_W'(s2_reg.budget_hi) << HALF_W) + BUDGET_W'(s2_reg.budget_lo);
        budget_spent = BUDGET_W'(sent_scaled_reg) >= budget;
        seq_gap      = s2_reg.entry_seq - halt_seq_reg;
    end

    // burst state update and verdict
    always_comb
    begin
        done_next        = done_reg;
        stop_armed_next  = stop_armed_reg;
        halt_seq_next    = halt_seq_reg;
        start_gen_next   = start_gen_reg;
        sent_scaled_next = sent_scaled_reg;
        cursor_next      = cursor_reg;
        send             = 1'b0;

        unique case (s2_reg.mode)
            MODE_START:
            begin
                start_gen_next   = s2_reg.generation;
                done_next        = 1'b0;
                stop_armed_next  = 1'b0;
                halt_seq_next    = '0;
                sent_scaled_next = '0;
                cursor_next      = '0;
            end
            MODE_TERM:
            begin
                if (!s2_reg.stop_requested)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    halt_seq_next   = s2_reg.halt_seq;
                    stop_armed_next = 1'b1;
                end
            end
            MODE_POLL:
            begin
                if (!done_reg)
                begin
                    priority if (s2_reg.generation != start_gen_reg || s2_reg.cap_hit
                                 || cursor_reg >= s2_reg.count)
                    begin
                        done_next = 1'b1;
                    end
                    else if (budget_spent || !s2_reg.entry_valid)
                    begin
                        done_next = 1'b0;
                    end
                    else if (stop_armed_reg && !seq_gap[SEQ_W-1])
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        send             = 1'b1;
                        sent_scaled_next = sent_scaled_reg + SCALED_W'(s2_reg.len_scaled);
                        cursor_next      = cursor_reg + INDEX_BITS'(1);
                        done_next        = (cursor_reg + INDEX_BITS'(1)) >= s2_reg.count;
                    end
                end
            end
            default:
            begin
                done_next = done_reg;
            end
        endcase

        result_next.verdict     = send ? VERDICT_SEND : (done_next ? VERDICT_DONE : VERDICT_WAIT);
        result_next.entry_index = send ? INDEX_W'(cursor_reg) : '0;
        result_next.send_seq    = send ? s2_reg.entry_seq : '0;
        result_next.finished    = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            stop_armed_reg  <= 1'b0;
            halt_seq_reg    <= '0;
            start_gen_reg   <= '0;
            sent_scaled_reg <= '0;
            cursor_reg      <= '0;
        end
        else if (en_out && s2_valid_reg)
        begin
            done_reg        <= done_next;
            stop_armed_reg  <= stop_armed_next;
            halt_seq_reg    <= halt_seq_next;
            start_gen_reg   <= start_gen_next;
            sent_scaled_reg <= sent_scaled_next;
            cursor_reg      <= cursor_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: sim/retransmit_burst_pacer_unit_tb.sv
`timescale 1ns / 1ps

module retransmit_burst_pacer_unit_tb;
    import rbp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 4;
    localparam int PIPE_CYCLES  = 3;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [79:0] BIT_US_PER_BYTE = 80'd8000000;
    localparam int unsigned US_PER_MS_TB = 1000;
    localparam int unsigned ELAPSED_MAX = (1 << ELAPSED_W) - 1;
    localparam int MAX_POLLS_PER_BURST = 60;

    // block ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   item_valid = 1'b0;
    logic                   item_ready;
    item_word_t             item = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_word_t           result;

    // pacer state as this side tracks it
    logic [MULT_W-1:0] cfg_mult_q8 = RATE_MULT_RESET;
    logic [CAP_W-1:0]  cfg_cap_ms = DURATION_CAP_RESET;
    logic              pace_done = 1'b0;
    logic              pace_stop_armed = 1'b0;
    logic [15:0]       pace_halt_seq = '0;
    logic [31:0]       pace_generation = '0;
    logic [39:0]       pace_target_bps = '0;
    logic [47:0]       pace_bytes_sent = '0;
    logic [15:0]       pace_cursor = '0;
    result_word_t      pacing_expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int n_starts = 0, n_terms = 0, n_polls = 0, n_other = 0;
    int n_send = 0, n_wait = 0, n_done = 0;
    result_word_t want;

    retransmit_burst_pacer_unit #(
        .INDEX_BITS(16)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // pacing decision for one accepted word
    task automatic predict_pacing(input item_word_t w);
        logic [43:0]  scaled;
        logic [39:0]  rate;
        logic [79:0]  spent_bits;
        logic [79:0]  budget_bits;
        logic [48:0]  bytes_sum;
        logic         sent;
        result_word_t r;
        r = '0;
        sent = 1'b0;
        case (w.mode)
            MODE_START:
            begin
                scaled = 44'(w.base_rate_bps) * 44'(cfg_mult_q8);
                rate = 40'(scaled >> 8);
                if (w.client_cap_bps != '0 && 40'(w.client_cap_bps) < rate)
                    rate = 40'(w.client_cap_bps);
                pace_target_bps = rate;
                pace_generation = w.channel_generation;
                pace_done = 1'b0;
                pace_stop_armed = 1'b0;
                pace_halt_seq = '0;
                pace_bytes_sent = '0;
                pace_cursor = '0;
            end
            MODE_POLL:
            begin
                // cache_count is only 16 bits, so the clamp to the index range never bites
                if (!pace_done)
                begin
                    spent_bits = 80'(pace_bytes_sent) * BIT_US_PER_BYTE;
                    budget_bits = 80'(pace_target_bps) * 80'(w.elapsed_us);
                    if (w.channel_generation != pace_generation
                        || 32'(w.elapsed_us) >= 32'(cfg_cap_ms) * US_PER_MS_TB
                        || pace_cursor >= w.cache_count)
                        pace_done = 1'b1;
                    else if (spent_bits < budget_bits && w.entry_valid)
                    begin
                        // serial distance to the stop sequence, half the space counts as reached
                        if (pace_stop_armed && 16'(w.entry_seq - pace_halt_seq) < 16'h8000)
                            pace_done = 1'b1;
                        else
                        begin
                            sent = 1'b1;
                            r.verdict = VERDICT_SEND;
                            r.entry_index = pace_cursor;
                            r.send_seq = w.entry_seq;
                            bytes_sum = 49'(pace_bytes_sent) + 49'(w.entry_len);
                            pace_bytes_sent = bytes_sum[48] ? '1 : bytes_sum[47:0];
                            pace_cursor = pace_cursor + 16'd1;
                            if (pace_cursor >= w.cache_count)
                                pace_done = 1'b1;
                        end
                    end
                end
            end
            MODE_TERM:
            begin
                if (!w.stop_requested)
                    pace_done = 1'b1;
                else
                begin
                    pace_halt_seq = w.halt_seq;
                    pace_stop_armed = 1'b1;
                end
            end
            default:
            begin
                // unused code leaves the state alone
            end
        endcase
        if (!sent)
            r.verdict = pace_done ? VERDICT_DONE : VERDICT_WAIT;
        r.finished = pace_done;
        pacing_expected_q.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // result checker and receiver stall
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            if (pacing_expected_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected, got %p", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = pacing_expected_q.pop_front();
                check_field("verdict", 32'(want.verdict), 32'(result.verdict));
                check_field("entry_index", 32'(want.entry_index), 32'(result.entry_index));
                check_field("send_seq", 32'(want.send_seq), 32'(result.send_seq));
                check_field("finished", 32'(want.finished), 32'(result.finished));
                if (want.verdict == VERDICT_SEND)
                    n_send++;
                else if (want.verdict == VERDICT_WAIT)
                    n_wait++;
                else
                    n_done++;
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one word, leaving valid high after acceptance
    task automatic send_item(input item_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        predict_pacing(w);
        case (w.mode)
            MODE_START: n_starts++;
            MODE_TERM:  n_terms++;
            MODE_POLL:  n_polls++;
            default:    n_other++;
        endcase
    endtask

    // wait until every word has come back and the pipeline is empty
    task automatic settle_pipeline();
        item_valid <= 1'b0;
        while (pacing_expected_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 2) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_RATE_MULT)
            cfg_mult_q8 = data[MULT_W-1:0];
        else
            cfg_cap_ms = data;
    endtask

    task automatic configure_pacer(input logic [MULT_W-1:0] mult, input logic [CAP_W-1:0] cap);
        settle_pipeline();
        write_register(CFG_RATE_MULT, CFG_DATA_W'(mult));
        write_register(CFG_DURATION_CAP, cap);
        cfg_valid <= 1'b0;
    endtask

    // word with every field random, so unused fields get exercised
    function automatic item_word_t filler_word();
        item_word_t w;
        w.mode = MODE_W'($urandom_range(3));
        w.elapsed_us = ELAPSED_W'($urandom);
        w.cache_count = COUNT_W'($urandom);
        w.channel_generation = $urandom;
        w.entry_valid = 1'($urandom);
        w.entry_seq = SEQ_W'($urandom);
        w.entry_len = LEN_W'($urandom);
        w.base_rate_bps = $urandom;
        w.client_cap_bps = $urandom;
        w.stop_requested = 1'($urandom);
        w.halt_seq = SEQ_W'($urandom);
        return w;
    endfunction

    function automatic item_word_t start_word(input logic [31:0] gen, input logic [31:0] nominal,
                                              input logic [31:0] client);
        item_word_t w;
        w = filler_word();
        w.mode = MODE_START;
        w.channel_generation = gen;
        w.base_rate_bps = nominal;
        w.client_cap_bps = client;
        return w;
    endfunction

    function automatic item_word_t poll_word(input logic [ELAPSED_W-1:0] elapsed,
                                             input logic [15:0] count, input logic [31:0] gen,
                                             input logic valid, input logic [15:0] seq,
                                             input logic [15:0] len);
        item_word_t w;
        w = filler_word();
        w.mode = MODE_POLL;
        w.elapsed_us = elapsed;
        w.cache_count = count;
        w.channel_generation = gen;
        w.entry_valid = valid;
        w.entry_seq = seq;
        w.entry_len = len;
        return w;
    endfunction

    function automatic item_word_t term_word(input logic req, input logic [15:0] seq);
        item_word_t w;
        w = filler_word();
        w.mode = MODE_TERM;
        w.stop_requested = req;
        w.halt_seq = seq;
        return w;
    endfunction

    // polls with no start yet: zero rate and zero generation
    task automatic test_unstarted_polls();
        send_item(poll_word(26'd100, 16'd5, 32'd0, 1'b1, 16'd1, 16'd10));
        send_item(poll_word(26'd100, 16'd5, 32'd1, 1'b1, 16'd1, 16'd10));
        send_item(poll_word(26'd200, 16'd5, 32'd0, 1'b1, 16'd1, 16'd10));
    endtask

    // one word per decision path at reset settings
    task automatic test_directed_cases();
        item_word_t w;
        // full nominal rate, nothing may go at time zero
        send_item(start_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        send_item(poll_word(26'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        send_item(poll_word(26'd1000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        send_item(poll_word(26'd1001, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 16'h0001, 16'd5));
        // armed stop: behind, exactly half way, then reached
        send_item(term_word(1'b1, 16'h0005));
        send_item(poll_word(26'd2000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0004, 16'd100));
        send_item(poll_word(26'd2000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h8005, 16'd100));
        send_item(poll_word(26'd2000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0005, 16'd100));
        w = filler_word();
        w.mode = MODE_UNUSED;
        send_item(w);
        // client limit below target, then generation change
        send_item(start_word(32'd7, 32'd1000000, 32'd500000));
        send_item(poll_word(26'd500, 16'd3, 32'd8, 1'b1, 16'd1, 16'd1));
        // zero rate never lets anything out
        send_item(start_word(32'd7, 32'd0, 32'd0));
        send_item(poll_word(26'd5000, 16'd3, 32'd7, 1'b1, 16'd1, 16'd1));
        // client limit above target is ignored; duration cap edges
        send_item(start_word(32'd9, 32'd1000000, 32'd2000000));
        send_item(poll_word(26'd9999999, 16'd3, 32'd9, 1'b1, 16'd2, 16'd0));
        send_item(poll_word(26'd10000000, 16'd3, 32'd9, 1'b1, 16'd3, 16'd0));
        // last entry sent finishes the burst, then done sticks
        send_item(start_word(32'd10, 32'd8000000, 32'd0));
        send_item(poll_word(26'd1, 16'd1, 32'd10, 1'b1, 16'd20, 16'd1));
        send_item(poll_word(26'd2, 16'd1, 32'd10, 1'b1, 16'd21, 16'd1));
        // budget exactly met waits, one more microsecond sends
        send_item(start_word(32'd11, 32'd8000000, 32'd0));
        send_item(poll_word(26'd1, 16'd4, 32'd11, 1'b1, 16'd30, 16'd1));
        send_item(poll_word(26'd1, 16'd4, 32'd11, 1'b1, 16'd31, 16'd1));
        send_item(poll_word(26'd2, 16'd4, 32'd11, 1'b1, 16'd31, 16'd1));
        send_item(term_word(1'b0, 16'd0));
        // empty cache ends at once
        send_item(start_word(32'd12, 32'd1000000, 32'd0));
        send_item(poll_word(26'd100, 16'd0, 32'd12, 1'b1, 16'd1, 16'd1));
    endtask

    // multiplier and cap at both ends of their range
    task automatic test_register_extremes();
        configure_pacer(12'd4095, 16'd0);
        send_item(start_word(32'd1, 32'hFFFF_FFFF, 32'd0));
        send_item(poll_word(26'd0, 16'd10, 32'd1, 1'b1, 16'd1, 16'd1));
        configure_pacer(12'd0, 16'hFFFF);
        send_item(start_word(32'd2, 32'hFFFF_FFFF, 32'd0));
        send_item(poll_word(26'd65534999, 16'd10, 32'd2, 1'b1, 16'd1, 16'd1));
        send_item(poll_word(26'h3FF_FFFF, 16'd10, 32'd2, 1'b1, 16'd1, 16'd1));
    endtask

    // random bursts: start, polls walking the cache, occasional terminates and noise
    task automatic test_paced_bursts(input logic [MULT_W-1:0] mult, input logic [CAP_W-1:0] cap,
                                     input int n_words);
        int          words;
        int          polls;
        int unsigned pick;
        int unsigned next_us;
        int unsigned cap_us;
        logic [31:0] gen;
        logic [31:0] poll_gen;
        logic [31:0] nominal;
        logic [31:0] client;
        logic [15:0] count;
        logic [15:0] poll_count;
        logic [15:0] base_seq;
        logic [15:0] seq;
        logic [15:0] len;
        logic [25:0] elapsed;
        logic [79:0] threshold_us;
        configure_pacer(mult, cap);
        words = 0;
        while (words < n_words)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(filler_word());
                words++;
            end
            else
            begin
                gen = ($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom;
                nominal = ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000, 50000000);
                client = ($urandom_range(1) == 0) ? 32'd0 : $urandom_range(10000, 80000000);
                pick = $urandom_range(99);
                count = (pick < 2) ? 16'd0 : (pick < 4) ? 16'hFFFF : 16'($urandom_range(1, 24));
                send_item(start_word(gen, nominal, client));
                words++;
                base_seq = 16'($urandom);
                if ($urandom_range(4) == 0)
                begin
                    send_item(term_word(1'b1, base_seq + 16'($urandom_range(0, 26))));
                    words++;
                end
                elapsed = 26'($urandom_range(0, 500));
                polls = 0;
                while (!pace_done && polls < MAX_POLLS_PER_BURST)
                begin
                    // elapsed time: on the budget edge, on the cap edge, or moving on
                    pick = $urandom_range(99);
                    cap_us = 32'(cfg_cap_ms) * US_PER_MS_TB;
                    if (pick < 30 && pace_target_bps != '0)
                    begin
                        threshold_us = (80'(pace_bytes_sent) * BIT_US_PER_BYTE)
                                       / 80'(pace_target_bps);
                        if (threshold_us >= 80'(ELAPSED_MAX))
                            elapsed = 26'(ELAPSED_MAX);
                        else
                            elapsed = 26'(threshold_us) + 26'($urandom_range(0, 1));
                    end
                    else if (pick < 33)
                        elapsed = (cap_us == 0) ? 26'd0 : 26'(cap_us - $urandom_range(0, 1));
                    else
                    begin
                        next_us = 32'(elapsed) + $urandom_range(0, 4000);
                        elapsed = (next_us > ELAPSED_MAX) ? 26'(ELAPSED_MAX) : 26'(next_us);
                    end
                    pick = $urandom_range(99);
                    if (pick < 3)
                        send_item(term_word(1'b0, 16'($urandom)));
                    else if (pick < 7)
                        send_item(term_word(1'b1, base_seq + pace_cursor
                                            + 16'($urandom_range(0, 4))));
                    else
                    begin
                        poll_gen = (pick < 10) ? gen ^ (32'd1 << $urandom_range(31)) : gen;
                        poll_count = ($urandom_range(19) == 0) ? 16'($urandom) : count;
                        seq = ($urandom_range(9) == 0) ? 16'($urandom) : base_seq + pace_cursor;
                        len = ($urandom_range(6) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 1500));
                        send_item(poll_word(elapsed, poll_count, poll_gen,
                                            $urandom_range(9) != 0, seq, len));
                    end
                    words++;
                    polls++;
                end
                // done must hold on a later poll
                if ($urandom_range(2) == 0)
                begin
                    send_item(poll_word(elapsed, count, gen, 1'b1, base_seq, 16'd1));
                    words++;
                end
            end
        end
    endtask

    // test sequence
    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 25;
        recv_idle_pct = 87;
        test_unstarted_polls();
        test_directed_cases();
        test_register_extremes();
        test_paced_bursts(RATE_MULT_RESET, DURATION_CAP_RESET, 270);
        send_idle_pct = 87;
        recv_idle_pct = 25;
        test_paced_bursts(12'd4095, 16'hFFFF, 270);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_paced_bursts(12'($urandom_range(1, 4095)), 16'($urandom_range(1, 65535)), 270);
        settle_pipeline();
        if (pacing_expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pacing_expected_q.size());
            mismatch_count++;
        end
        $display("covered %0d starts, %0d terminates, %0d polls, %0d unused-mode words",
                 n_starts, n_terms, n_polls, n_other);
        $display("checked %0d send, %0d wait, %0d done verdicts; %0d mismatches",
                 n_send, n_wait, n_done, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
